>>> hdl/sre_pkg.sv
// Shared constants and register index codes for the skybox ray end clamp.
// No dependencies; imported by sre_div and skybox_ray_end_clamp_core.
package sre_pkg;

	localparam int SRE_COORD_WIDTH = 32;
	localparam int SRE_FRAC_BITS   = 16;

	typedef enum logic [0:0] {
		CFG_HALF_SIDE = 1'b0,
		CFG_ZERO_FAR  = 1'b1
	} cfg_idx_t;

endpackage

>>> hdl/sre_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on sre_pkg for the default coordinate width.
module sre_div import sre_pkg::*; #(
	parameter int CW = SRE_COORD_WIDTH
) (
	input  logic            clk,
	input  logic            adv,
	input  logic [2*CW:0]   num,
	input  logic [CW:0]     den,
	output logic [CW-1:0]   quo,
	output logic            ovf
);

	logic [CW:0]   rem_s [0:CW];
	logic [CW-1:0] lo_s  [0:CW];
	logic [CW-1:0] quo_s [0:CW];
	logic [CW:0]   den_s [0:CW];
	logic          ovf_s [0:CW];

	// quotient overflows CW bits when the upper part already reaches the divisor
	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= num[2*CW:CW];
			lo_s[0]  <= num[CW-1:0];
			quo_s[0] <= '0;
			den_s[0] <= den;
			ovf_s[0] <= (num[2*CW:CW] >= den);
		end
	end

	for (genvar i = 1; i <= CW; i++) begin : g_step
		logic [CW+1:0] trial;
		logic [CW+1:0] diff;
		logic          ge;

		assign trial = {rem_s[i-1], lo_s[i-1][CW-1]};
		assign diff  = trial - {1'b0, den_s[i-1]};
		assign ge    = (trial >= {1'b0, den_s[i-1]});

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i] <= ge ? diff[CW:0] : trial[CW:0];
				lo_s[i]  <= {lo_s[i-1][CW-2:0], 1'b0};
				quo_s[i] <= {quo_s[i-1][CW-2:0], ge};
				den_s[i] <= den_s[i-1];
				ovf_s[i] <= ovf_s[i-1];
			end
		end
	end

	assign quo = quo_s[CW];
	assign ovf = ovf_s[CW];

endmodule

>>> hdl/skybox_ray_end_clamp_core.sv
// Skybox ray end clamp: top level, config registers, candidate selection and output.
// Depends on sre_pkg and sre_div.
//
// One beat per ray, one result beat per input beat, in order. A new beat is taken every
// cycle while the output is not stalled; each beat passes the selection stages and then the
// one-bit-per-stage divider that scales the direction by the chosen exit parameter.
// End points outside the cube (or zero depth in far mode) are replaced by the nearest
// positive exit point of the ray on the cube faces, saturated; with no such exit the
// origin is returned and hit_found is low. Configuration writes take effect at once.
module skybox_ray_end_clamp_core import sre_pkg::*; #(
	parameter int FRAC_BITS   = SRE_FRAC_BITS,
	parameter int COORD_WIDTH = SRE_COORD_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  cfg_idx_t                      cfg_idx,
	input  logic [COORD_WIDTH-2:0]        cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] end_x,
	input  logic signed [COORD_WIDTH-1:0] end_y,
	input  logic signed [COORD_WIDTH-1:0] end_z,
	input  logic signed [COORD_WIDTH-1:0] depth,
	input  logic signed [COORD_WIDTH-1:0] ray_origin_x,
	input  logic signed [COORD_WIDTH-1:0] ray_origin_y,
	input  logic signed [COORD_WIDTH-1:0] ray_origin_z,
	input  logic signed [COORD_WIDTH-1:0] dir_x,
	input  logic signed [COORD_WIDTH-1:0] dir_y,
	input  logic signed [COORD_WIDTH-1:0] dir_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] out_x,
	output logic signed [COORD_WIDTH-1:0] out_y,
	output logic signed [COORD_WIDTH-1:0] out_z,
	output logic                          was_clamped,
	output logic                          hit_found
);

	localparam int CW = COORD_WIDTH;
	localparam logic [CW-2:0] R_RESET = (CW-1)'(1) << FRAC_BITS;

	typedef struct packed {
		logic [2:0][CW-1:0] base;
		logic [2:0]         neg;
		logic [2:0]         use_q;
		logic               clamp;
		logic               found;
	} side_t;

	logic [CW-2:0] half_q;
	logic          zero_far_q;
	logic          adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q     <= R_RESET;
			zero_far_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_HALF_SIDE: half_q     <= cfg_data;
				CFG_ZERO_FAR:  zero_far_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// stage 1: outside test and per-axis exit candidate
	logic signed [CW-1:0] e_in [3];
	logic signed [CW-1:0] o_in [3];
	logic signed [CW-1:0] v_in [3];
	logic [2:0]           outside;
	logic [2:0]           c_ok;
	logic [CW-1:0]        c_n [3];
	logic [CW-1:0]        c_d [3];

	assign e_in = '{end_x, end_y, end_z};
	assign o_in = '{ray_origin_x, ray_origin_y, ray_origin_z};
	assign v_in = '{dir_x, dir_y, dir_z};

	always_comb begin
		logic signed [CW:0] rs;
		logic signed [CW:0] na;
		logic signed [CW:0] nb;
		logic [CW-1:0]      em;
		logic               na_pos, na_neg, nb_pos, nb_neg;
		rs = signed'({2'b00, half_q});
		for (int k = 0; k < 3; k++) begin
			em         = e_in[k][CW-1] ? CW'(-e_in[k]) : CW'(e_in[k]);
			outside[k] = em > {1'b0, half_q};
			na         = rs - (CW+1)'(o_in[k]);
			nb         = -rs - (CW+1)'(o_in[k]);
			na_neg     = na[CW];
			nb_neg     = nb[CW];
			na_pos     = !na[CW] && (na != '0);
			nb_pos     = !nb[CW] && (nb != '0);
			c_d[k]     = v_in[k][CW-1] ? CW'(-v_in[k]) : CW'(v_in[k]);
			c_ok[k]    = 1'b0;
			c_n[k]     = '0;
			if (v_in[k] != '0) begin
				priority if (!v_in[k][CW-1] && nb_pos) begin
					c_ok[k] = 1'b1;
					c_n[k]  = CW'(nb);
				end else if (!v_in[k][CW-1] && na_pos) begin
					c_ok[k] = 1'b1;
					c_n[k]  = CW'(na);
				end else if (v_in[k][CW-1] && na_neg) begin
					c_ok[k] = 1'b1;
					c_n[k]  = CW'(-na);
				end else if (v_in[k][CW-1] && nb_neg) begin
					c_ok[k] = 1'b1;
					c_n[k]  = CW'(-nb);
				end
			end
		end
	end

	logic               valid_s1, valid_s2, valid_s3, valid_s4;
	logic               clamp_s1, clamp_s2, clamp_s3;
	logic [2:0][CW-1:0] base_s1, base_s2, base_s3;
	logic [2:0]         neg_s1, neg_s2, neg_s3;
	logic [2:0]         vnz_s1, vnz_s2, vnz_s3;
	logic [2:0]         cok_s1;
	logic [CW-1:0]      cn_s1 [3];
	logic [CW-1:0]      cd_s1 [3];
	logic               wok_s2, cok2_s2;
	logic [CW-1:0]      wn_s2, wd_s2, cn2_s2;
	logic [CW-1:0]      cd_s2 [3];
	logic               found_s3;
	logic [CW-1:0]      bn_s3, bd_s3;
	logic [CW-1:0]      cd_s3 [3];
	side_t              side_s4;
	logic [2*CW:0]      num_s4 [3];
	logic [CW:0]        den_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			clamp_s1 <= (|outside) || (zero_far_q && (depth == '0));
			for (int k = 0; k < 3; k++) begin
				base_s1[k] <= ((|outside) || (zero_far_q && (depth == '0))) ? o_in[k] : e_in[k];
				neg_s1[k]  <= v_in[k][CW-1];
				vnz_s1[k]  <= (v_in[k] != '0);
				cn_s1[k]   <= c_n[k];
				cd_s1[k]   <= c_d[k];
			end
			cok_s1 <= c_ok;
		end
	end

	// stage 2: earlier of candidates x and y, compared as cross products
	logic [2*CW-1:0] pa2, pb2;
	logic            pick1;

	assign pa2   = cn_s1[0] * cd_s1[1];
	assign pb2   = cn_s1[1] * cd_s1[0];
	assign pick1 = cok_s1[1] && (!cok_s1[0] || (pb2 < pa2));

	always_ff @(posedge clk) begin
		if (adv) begin
			clamp_s2 <= clamp_s1;
			base_s2  <= base_s1;
			neg_s2   <= neg_s1;
			vnz_s2   <= vnz_s1;
			wok_s2   <= cok_s1[0] || cok_s1[1];
			wn_s2    <= pick1 ? cn_s1[1] : cn_s1[0];
			wd_s2    <= pick1 ? cd_s1[1] : cd_s1[0];
			cok2_s2  <= cok_s1[2];
			cn2_s2   <= cn_s1[2];
			cd_s2    <= cd_s1;
		end
	end

	// stage 3: against candidate z
	logic [2*CW-1:0] pa3, pb3;
	logic            pick2;

	assign pa3   = wn_s2 * cd_s2[2];
	assign pb3   = cn2_s2 * wd_s2;
	assign pick2 = cok2_s2 && (!wok_s2 || (pb3 < pa3));

	always_ff @(posedge clk) begin
		if (adv) begin
			clamp_s3 <= clamp_s2;
			base_s3  <= base_s2;
			neg_s3   <= neg_s2;
			vnz_s3   <= vnz_s2;
			found_s3 <= wok_s2 || cok2_s2;
			bn_s3    <= pick2 ? cn2_s2 : wn_s2;
			bd_s3    <= pick2 ? cd_s2[2] : wd_s2;
			cd_s3    <= cd_s2;
		end
	end

	// stage 4: rounded quotient numerators 2*|v|*n + d over 2*d
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4.clamp <= clamp_s3;
			side_s4.found <= found_s3;
			side_s4.base  <= base_s3;
			side_s4.neg   <= neg_s3;
			for (int k = 0; k < 3; k++) begin
				side_s4.use_q[k] <= clamp_s3 && found_s3 && vnz_s3[k];
				num_s4[k]        <= {(2*CW)'(cd_s3[k]) * (2*CW)'(bn_s3), 1'b0}
					+ (2*CW+1)'(bd_s3);
			end
			den_s4 <= {bd_s3, 1'b0};
		end
	end

	logic [CW-1:0] quo [3];
	logic [2:0]    qovf;

	for (genvar k = 0; k < 3; k++) begin : g_lane
		sre_div #(.CW(CW)) u_div (
			.clk (clk),
			.adv (adv),
			.num (num_s4[k]),
			.den (den_s4),
			.quo (quo[k]),
			.ovf (qovf[k])
		);
	end

	side_t side_s [0:CW];
	logic  vld_s  [0:CW];

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= side_s4;
			for (int i = 1; i <= CW; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= CW; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= valid_s4;
			for (int i = 1; i <= CW; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// output stage: origin +/- quotient, saturated
	side_t                      fin;
	logic [2:0][CW-1:0]         res;
	logic [2:0][CW-1:0]         out_q;
	logic                       clamp_q, found_q, out_valid_q;

	assign fin = side_s[CW];

	always_comb begin
		logic signed [CW+1:0] sum;
		logic signed [CW+1:0] qx;
		for (int k = 0; k < 3; k++) begin
			qx  = signed'({2'b00, quo[k]});
			sum = (CW+2)'(signed'(fin.base[k])) + (fin.neg[k] ? -qx : qx);
			if (!fin.use_q[k]) begin
				res[k] = fin.base[k];
			end else if (qovf[k]) begin
				res[k] = fin.neg[k] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
			end else if ((sum[CW+1:CW-1] != '0) && (sum[CW+1:CW-1] != '1)) begin
				res[k] = sum[CW+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
			end else begin
				res[k] = sum[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s[CW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q   <= res;
			clamp_q <= fin.clamp;
			found_q <= !fin.clamp || fin.found;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_x       = out_q[0];
	assign out_y       = out_q[1];
	assign out_z       = out_q[2];
	assign was_clamped = clamp_q;
	assign hit_found   = found_q;

`ifndef SYNTHESIS
	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a blocked result");

	a_unclamped_hits: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !was_clamped) |-> hit_found)
		else $error("unclamped result reports no hit");

	a_no_scale_without_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[CW] && !fin.found) |-> (fin.use_q == 3'b000))
		else $error("scaling requested with no exit found");

	a_cfg_far: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && (cfg_idx == CFG_ZERO_FAR)) |=> (zero_far_q == $past(cfg_data[0])))
		else $error("zero depth mode write lost");
`endif

endmodule
